@@ design/pssu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssu_pkg
// Types and constants shared by the star streak update block.
// ----------------------------------------------------------------------------
package pssu_pkg;

  localparam int STAR_COUNT_DEF   = 256;
  localparam int SHADE_LEVELS_DEF = 8;

  localparam logic       CMD_LOAD    = 1'b0;
  localparam logic       CMD_ADVANCE = 1'b1;

  localparam logic [16:0] DEPTH_ONE = 17'd65536;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_Z_STEP        = 2'd2;
  localparam logic [1:0] REG_BASE_COLOR    = 2'd3;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd768;
  localparam logic [14:0] Z_STEP_RST        = 15'd655;
  localparam logic [23:0] BASE_COLOR_RST    = 24'hFFFFFF;

  typedef struct packed {
    logic              command;
    logic [7:0]        star_index;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [16:0]       new_z;
  } item_t;

  typedef struct packed {
    logic              draw_valid;
    logic              respawned;
    logic signed [15:0] old_px;
    logic signed [15:0] old_py;
    logic signed [15:0] new_px;
    logic signed [15:0] new_py;
    logic [23:0]       shade_color;
  } result_t;

endpackage

@@ design/perspective_star_streak_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_star_streak_update
// Star table with perspective projection of old and new positions per advance.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  item    | in        | item_valid / item_stall      | item   (pssu_pkg::item_t)
//  result  | out       | result_valid / result_stall  | result (pssu_pkg::result_t)
//  config  | in        | cfg_we                       | cfg_index, cfg_data
//
// A load or out-of-range item goes straight to the result; an advance takes one
// table read, then four projections (multiply, overflow check, 16 steps of a
// shared radix-2 divider), then shading. A streak whose new x or new y is off
// screen stops after that projection. One item is in flight at a time; the next
// is taken once the result sits in the output register.
// Synchronous reset clears control and configuration; the table needs no clearing.
// ----------------------------------------------------------------------------
module perspective_star_streak_update #(
  parameter int STAR_COUNT   = pssu_pkg::STAR_COUNT_DEF,
  parameter int SHADE_LEVELS = pssu_pkg::SHADE_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pssu_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output pssu_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_PRE    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_SHADE  = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [14:0] z_step;
  logic [23:0] base_color;

  logic [48:0] star_mem [STAR_COUNT];
  logic [48:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [48:0] mem_wdata;

  logic [2:0]  state;
  pssu_pkg::item_t   item_q;
  pssu_pkg::result_t res_q;
  logic signed [15:0] x_r, y_r;
  logic [16:0] zo_r, zn_r;
  logic [1:0]  op;
  logic [30:0] rem;
  logic        neg;
  logic [17:0] den;
  logic [32:0] dsr;
  logic [15:0] quo;
  logic        ovf;
  logic [3:0]  cnt;

  logic        accept;
  logic        in_range;
  logic        q_in_range;

  // Read path decode.
  logic signed [15:0] rd_x, rd_y;
  logic [16:0] rd_z;
  logic signed [17:0] zn_s;

  // Projection datapath.
  logic [12:0] scale;
  logic signed [15:0] coord;
  logic [16:0] zsel;
  logic signed [18:0] sum;
  logic signed [32:0] prod;
  logic [32:0] prod_abs;

  logic        ge;
  logic [15:0] qf;
  logic signed [15:0] sat_val;
  logic        off;

  // Shading.
  logic [15:0] diff;
  logic [24:0] lvl_prod;
  logic [8:0]  lvl;
  logic [8:0]  fct;
  logic [16:0] ch_r, ch_g, ch_b;
  logic [23:0] shade;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign in_range   = {9'd0, item.star_index} < 17'(STAR_COUNT);
  assign q_in_range = {9'd0, item_q.star_index} < 17'(STAR_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= pssu_pkg::SCREEN_WIDTH_RST;
      screen_height <= pssu_pkg::SCREEN_HEIGHT_RST;
      z_step        <= pssu_pkg::Z_STEP_RST;
      base_color    <= pssu_pkg::BASE_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pssu_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        pssu_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        pssu_pkg::REG_Z_STEP:        z_step        <= cfg_data[14:0];
        pssu_pkg::REG_BASE_COLOR:    base_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table entry is {x, y, z}.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(item_q.star_index);
    mem_wdata = {item_q.new_x, item_q.new_y, pssu_pkg::DEPTH_ONE};
    case (state)
      ST_IDLE: begin
        mem_we    = accept && in_range && (item.command == pssu_pkg::CMD_LOAD);
        mem_waddr = AW'(item.star_index);
        mem_wdata = {item.new_x, item.new_y, item.new_z};
      end
      ST_RESP: mem_we = 1'b1;
      ST_SHADE: begin
        mem_we    = 1'b1;
        mem_wdata = {x_r, y_r, zn_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      star_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= star_mem[AW'(item.star_index)];
  end

  assign rd_x = rd_data[48:33];
  assign rd_y = rd_data[32:17];
  assign rd_z = rd_data[16:0];
  assign zn_s = $signed({1'b0, rd_z}) - $signed({3'b000, z_step});

  assign scale    = op[0] ? screen_height : screen_width;
  assign coord    = op[0] ? y_r : x_r;
  assign zsel     = op[1] ? zo_r : zn_r;
  assign sum      = $signed({2'b00, zsel}) + 19'($signed({coord, 1'b0}));
  assign prod     = 33'($signed({1'b0, scale})) * 33'(sum);
  assign prod_abs = prod[32] ? 33'(-prod) : prod;

  assign ge = {2'b00, rem} >= dsr;
  assign qf = {quo[14:0], ge};

  // Truncation toward zero: the magnitude is divided, then the sign restored.
  always_comb begin
    if (ovf || qf[15]) begin
      sat_val = neg ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sat_val = neg ? -$signed(qf) : $signed(qf);
    end
    off = ovf || (neg && (qf != 16'd0)) || (qf >= {3'd0, scale});
  end

  always_comb begin
    diff     = (zn_r < pssu_pkg::DEPTH_ONE) ? 16'(pssu_pkg::DEPTH_ONE - zn_r) : 16'd0;
    lvl_prod = 25'(diff) * 25'(SHADE_LEVELS);
    lvl      = lvl_prod[24:16];
    if (lvl > 9'(SHADE_LEVELS - 1)) begin
      lvl = 9'(SHADE_LEVELS - 1);
    end
    fct  = lvl + 9'd1;
    ch_r = 17'(base_color[23:16]) * 17'(fct) / 17'(SHADE_LEVELS);
    ch_g = 17'(base_color[15:8])  * 17'(fct) / 17'(SHADE_LEVELS);
    ch_b = 17'(base_color[7:0])   * 17'(fct) / 17'(SHADE_LEVELS);
    shade = {ch_r[7:0], ch_g[7:0], ch_b[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != ST_FINISH) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            item_q <= item;
            res_q  <= '0;
            op     <= 2'd0;
            if (in_range && item.command == pssu_pkg::CMD_ADVANCE) begin
              state <= ST_READ;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_READ: begin
          x_r  <= rd_x;
          y_r  <= rd_y;
          zo_r <= rd_z;
          zn_r <= zn_s[16:0];
          if (q_in_range && zn_s > $signed({3'b000, z_step})) begin
            state <= ST_MUL;
          end else begin
            state <= ST_RESP;
          end
        end
        ST_MUL: begin
          rem   <= prod_abs[30:0];
          neg   <= prod[32];
          den   <= {zsel, 1'b0};
          state <= ST_PRE;
        end
        ST_PRE: begin
          ovf   <= {3'b000, rem} >= {den, 16'd0};
          dsr   <= {den, 15'd0};
          quo   <= 16'd0;
          cnt   <= 4'd0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (ge) begin
            rem <= rem - dsr[30:0];
          end
          quo <= qf;
          dsr <= dsr >> 1;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            case (op)
              2'd0: res_q.new_px <= sat_val;
              2'd1: res_q.new_py <= sat_val;
              2'd2: res_q.old_px <= sat_val;
              default: res_q.old_py <= sat_val;
            endcase
            op <= op + 2'd1;
            if (!op[1] && off) begin
              state <= ST_RESP;
            end else if (op == 2'd3) begin
              state <= ST_SHADE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_SHADE: begin
          res_q.draw_valid  <= 1'b1;
          res_q.shade_color <= shade;
          state             <= ST_FINISH;
        end
        ST_RESP: begin
          res_q <= {1'b0, q_in_range, ($bits(pssu_pkg::result_t) - 2)'(0)};
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!result_valid || !result_stall) begin
            result       <= res_q;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
